/* sv/rdc_pkg.sv */
// Shared constants, types and helper functions for the radix digit converter.
package rdc_pkg;

    localparam int VALUE_BITS    = 31;
    localparam int MAX_DIGITS    = 31;
    localparam int RADIX_W       = 5;
    localparam int DIGIT_W       = 4;
    localparam int CHAR_W        = 7;
    localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W         = $clog2(MAX_DIGITS);
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS + 1);
    localparam int IN_TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((CHAR_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(65);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } t_div_rsp;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] v;
        v = r;
        if (v < RADIX_MIN) v = RADIX_MIN;
        if (v > RADIX_MAX) v = RADIX_MAX;
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
        end
        return c;
    endfunction

endpackage

/* sv/rdc_divider.sv */
// Iterative divider: value by radix, a few quotient bits per cycle.
module rdc_divider import rdc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [DIV_W-1:0]    r_acc;
    logic [RADIX_W-1:0]  r_rem;
    logic [RADIX_W-1:0]  r_div;
    logic [DIV_W-1:0]    n_acc;
    logic [RADIX_W-1:0]  n_rem;

    always_comb begin
        logic [DIV_W-1:0]   acc;
        logic [RADIX_W-1:0] rem;
        acc = r_acc;
        rem = r_rem;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            rem = {rem[RADIX_W-2:0], acc[DIV_W-1]};
            acc = {acc[DIV_W-2:0], 1'b0};
            if (rem >= r_div) begin
                rem    = rem - r_div;
                acc[0] = 1'b1;
            end
        end
        n_acc = acc;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= DIV_W'(i_req.dividend);
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_acc[VALUE_BITS-1:0];
    assign o_rsp.remainder = r_rem[DIGIT_W-1:0];

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_req.start) |=> r_done)
        else $error("divider missed done");

endmodule

/* sv/rdc_digit_stack.sv */
// Remainder stack memory with registered read port.
module rdc_digit_stack import rdc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  logic [DIGIT_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output logic [DIGIT_W-1:0] o_rd_data
);

    logic [DIGIT_W-1:0] r_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/radix_digit_converter.sv */
// Top level: integer to radix digit string converter with sequencer.
//
// Input stream s_axis carries one value (tdata[30:0]); output stream m_axis
// carries one ASCII digit per transaction, most significant first, with
// tlast on the least significant digit. The configuration channel writes
// the radix (2 to 16, values outside are clamped); write it only while idle.
// A value is taken when the block is idle; it then stays not ready until
// its final digit has been loaded into the output register.
// Each digit is divided in the shared divider (four quotient bits per cycle
// over 32 bits); when all digits are stacked, each is read from the stack
// and loaded into the output register. A value of zero yields no transaction.
// The output register holds a digit while m_axis_tready is low and stalls
// the read-out; the divider is not affected by the receiver.
// Reset (synchronous, active low) returns to idle, drops any pending digit
// and sets the radix to ten. The digit stack needs no clearing.
module radix_digit_converter import rdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [30:0] value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] digit_char
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RADIX_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [RADIX_W-1:0]    r_radix;
    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;

    t_div_req              w_req;
    t_div_rsp              w_rsp;
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [DIGIT_W-1:0]    w_rd_data;
    logic [VALUE_BITS-1:0] w_in_value;

    assign w_in_value = s_axis_tdata[VALUE_BITS-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    rdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    rdc_digit_stack u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_rsp.remainder),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        w_req.start    = 1'b0;
        w_req.dividend = r_q;
        w_req.divisor  = clamp_radix(r_radix);
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_in_value != '0) begin
                    n_q            = w_in_value;
                    n_count        = '0;
                    w_req.start    = 1'b1;
                    w_req.dividend = w_in_value;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    n_q     = w_rsp.quotient;
                    if (w_rsp.quotient == '0 || r_count == CNT_W'(MAX_DIGITS - 1)) begin
                        n_rd_idx = r_count[IDX_W-1:0];
                        n_state  = S_READ;
                    end else begin
                        w_req.start    = 1'b1;
                        w_req.dividend = w_rsp.quotient;
                    end
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (r_rd_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx - 1'b1;
                        n_state  = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_q         <= '0;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_q         <= n_q;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radix <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_char <= ascii_of(w_rd_data);
            r_out_last <= (r_rd_idx == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_char);
    assign m_axis_tlast  = r_out_last;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside division phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count < CNT_W'(MAX_DIGITS)))
        else $error("digit count overflow");

    a_q_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_q != '0))
        else $error("dividing a zero quotient");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_rd_idx == '0) |=> (r_state == S_IDLE && m_axis_tlast))
        else $error("final digit did not end the run");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("stack read above written entries");

endmodule
